// ----- hw/rtl/pq_pkg.sv -----
// Shared types and constants for the unsorted-array priority queue.
// No dependencies; every other file uses this package by scoped names.
package pq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_OUT_W = 5;

  // operation codes
  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_EXTRACT = 3'd1;
  localparam logic [2:0] OP_PEEK    = 3'd2;
  localparam logic [2:0] OP_MODIFY  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]     result_value;
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count_out;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/pq_mem.sv -----
// Entry store: one write port, one read port with registered read data.
// Depends on pq_pkg.
module pq_mem (
  input  logic              clk,
  input  pq_pkg::mem_req_t  req,
  output pq_pkg::entry_t    rdata
);

  pq_pkg::entry_t mem [pq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hw/rtl/pq_ctrl.sv -----
// Sequencer for the queue: decodes the operation, walks the store one entry
// per cycle through a single compare unit, and compacts on extract.
// Depends on pq_pkg; drives pq_mem through a mem_req_t.
module pq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  pq_pkg::in_word_t    req,
  output logic                res_valid,
  input  logic                res_ready,
  output pq_pkg::out_word_t   res,
  output pq_pkg::mem_req_t    mreq,
  input  pq_pkg::entry_t      rdata
);

  pq_pkg::state_t state, state_next;

  logic [2:0]               op_r, op_r_next;
  logic signed [31:0]       val_r, val_r_next;
  logic signed [31:0]       pri_r, pri_r_next;
  logic [pq_pkg::CNT_W-1:0] count, count_next;
  logic [pq_pkg::IDX_W-1:0] scan_idx, scan_idx_next;
  logic [pq_pkg::IDX_W-1:0] best_idx, best_idx_next;
  logic signed [31:0]       best_pri, best_pri_next;
  logic signed [31:0]       best_val, best_val_next;
  logic signed [31:0]       res_value, res_value_next;
  logic [1:0]               res_status, res_status_next;

  logic [pq_pkg::CNT_W-1:0]                        last_idx;
  logic                                            is_last;
  logic                                            take;
  logic [pq_pkg::IDX_W-1:0]                        sel_idx;
  logic signed [31:0]                              sel_pri;
  logic signed [31:0]                              sel_val;
  logic [pq_pkg::CNT_W+pq_pkg::COUNT_OUT_W-1:0]    count_ext;

  // shared compare unit: strict greater keeps the lowest index on ties
  assign last_idx = count - pq_pkg::CNT_W'(1);
  assign is_last  = (pq_pkg::CNT_W'(scan_idx) == last_idx);
  assign take     = (scan_idx == '0) || ($signed(rdata.prio) > best_pri);
  assign sel_idx  = take ? scan_idx : best_idx;
  assign sel_pri  = take ? $signed(rdata.prio) : best_pri;
  assign sel_val  = take ? $signed(rdata.value) : best_val;

  assign count_ext           = {{pq_pkg::COUNT_OUT_W{1'b0}}, count};
  assign res.result_value    = res_value;
  assign res.status          = res_status;
  assign res.entry_count_out = count_ext[pq_pkg::COUNT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    op_r       <= op_r_next;
    val_r      <= val_r_next;
    pri_r      <= pri_r_next;
    scan_idx   <= scan_idx_next;
    best_idx   <= best_idx_next;
    best_pri   <= best_pri_next;
    best_val   <= best_val_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    op_r_next       = op_r;
    val_r_next      = val_r;
    pri_r_next      = pri_r;
    count_next      = count;
    scan_idx_next   = scan_idx;
    best_idx_next   = best_idx;
    best_pri_next   = best_pri;
    best_val_next   = best_val;
    res_value_next  = res_value;
    res_status_next = res_status;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    mreq.we         = 1'b0;
    mreq.waddr      = scan_idx;
    mreq.wdata      = rdata;
    mreq.raddr      = '0;

    case (state)
      pq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_r_next  = req.op;
          val_r_next = req.item_value;
          pri_r_next = req.item_priority;
          state_next = pq_pkg::S_START;
        end
      end

      pq_pkg::S_START: begin
        res_value_next  = '0;
        res_status_next = pq_pkg::ST_OK;
        scan_idx_next   = '0;
        state_next      = pq_pkg::S_DONE;
        case (op_r)
          pq_pkg::OP_INSERT: begin
            if (count >= pq_pkg::CNT_W'(pq_pkg::QUEUE_DEPTH)) begin
              res_status_next = pq_pkg::ST_FULL;
            end else begin
              mreq.we          = 1'b1;
              mreq.waddr       = count[pq_pkg::IDX_W-1:0];
              mreq.wdata.value = val_r;
              mreq.wdata.prio  = pri_r;
              count_next       = count + pq_pkg::CNT_W'(1);
            end
          end
          pq_pkg::OP_EXTRACT, pq_pkg::OP_PEEK, pq_pkg::OP_MODIFY: begin
            if (count == '0) begin
              res_status_next = (op_r == pq_pkg::OP_MODIFY) ? pq_pkg::ST_NOTFOUND
                                                            : pq_pkg::ST_EMPTY;
            end else begin
              state_next = pq_pkg::S_SCAN;   // entry 0 is being read now
            end
          end
          pq_pkg::OP_CLEAR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end

      pq_pkg::S_SCAN: begin
        // rdata holds entry scan_idx; fetch the next one meanwhile
        mreq.raddr    = scan_idx + pq_pkg::IDX_W'(1);
        scan_idx_next = scan_idx + pq_pkg::IDX_W'(1);
        if (op_r == pq_pkg::OP_MODIFY) begin
          if ($signed(rdata.value) == val_r) begin
            mreq.we          = 1'b1;
            mreq.waddr       = scan_idx;
            mreq.wdata.value = rdata.value;
            mreq.wdata.prio  = pri_r;
            state_next       = pq_pkg::S_DONE;
          end else if (is_last) begin
            res_status_next = pq_pkg::ST_NOTFOUND;
            state_next      = pq_pkg::S_DONE;
          end
        end else begin
          best_idx_next = sel_idx;
          best_pri_next = sel_pri;
          best_val_next = sel_val;
          if (is_last) begin
            res_value_next = sel_val;
            if (op_r == pq_pkg::OP_PEEK) begin
              state_next = pq_pkg::S_DONE;
            end else if (pq_pkg::CNT_W'(sel_idx) == last_idx) begin
              count_next = count - pq_pkg::CNT_W'(1);
              state_next = pq_pkg::S_DONE;
            end else begin
              // start compaction at the winner
              mreq.raddr    = sel_idx + pq_pkg::IDX_W'(1);
              scan_idx_next = sel_idx;
              state_next    = pq_pkg::S_SHIFT;
            end
          end
        end
      end

      pq_pkg::S_SHIFT: begin
        // rdata holds entry scan_idx+1; move it down one place
        mreq.we       = 1'b1;
        mreq.waddr    = scan_idx;
        mreq.wdata    = rdata;
        mreq.raddr    = scan_idx + pq_pkg::IDX_W'(2);
        scan_idx_next = scan_idx + pq_pkg::IDX_W'(1);
        if (pq_pkg::CNT_W'(scan_idx) + pq_pkg::CNT_W'(1) == last_idx) begin
          count_next = count - pq_pkg::CNT_W'(1);
          state_next = pq_pkg::S_DONE;
        end
      end

      pq_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = pq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = pq_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pq_pkg::CNT_W'(pq_pkg::QUEUE_DEPTH))
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == pq_pkg::S_SCAN || state == pq_pkg::S_SHIFT) |->
      pq_pkg::CNT_W'(scan_idx) < count)
    else $error("scan index outside held entries");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == pq_pkg::S_IDLE || state == pq_pkg::S_DONE) |=> $stable(count))
    else $error("entry count changed outside an operation");

endmodule

// ----- hw/rtl/priority_queue_unsorted_array.sv -----
// Top level of the unsorted-array priority queue.
// Depends on pq_pkg, pq_mem and pq_ctrl.
//
// Usage
//   req channel (req_valid/req_ready/req): one word per operation - insert,
//   extract highest, peek highest, modify priority, clear. Codes 5 to 7 do
//   nothing and report ok.
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one word per request, in
//   order: result value (zero unless extract/peek succeeded), status and
//   the entry count after the operation.
// Operation steps (N = entries held, D = 16 deep)
//   insert, clear, empty cases: go from the start state straight to done.
//   peek: scans all N entries; modify: stops at the first hit, at most N.
//   extract: scans all N entries, then moves each entry above the winner down.
//   The single compare unit and the one-read-port store visit one entry per
//   cycle, so the scan and the compaction set the run time.
//   One operation is in flight at a time; req_ready is high only while idle.
// Reset: synchronous, rst high; the queue comes up empty. Stored entries are
//   not cleared; only entries below the count are ever used.
// Stall: a finished word waits in the rsp register while the next request is
//   accepted; that request completes once the register frees up.
module priority_queue_unsorted_array (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  pq_pkg::in_word_t    req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output pq_pkg::out_word_t   rsp
);

  pq_pkg::mem_req_t  mreq;
  pq_pkg::entry_t    rdata;
  pq_pkg::out_word_t res;
  logic              res_valid;
  logic              res_ready;

  // output register frees when empty or being drained this cycle
  assign res_ready = !rsp_valid || rsp_ready;

  pq_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  pq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

// ----- test/priority_queue_unsorted_array_tb.sv -----
// Self-checking bench for priority_queue_unsorted_array: directed corner cases, then
// random insert/extract/peek/modify/clear runs under changing back-pressure.
// Depends on pq_pkg and the block's RTL only.
module priority_queue_unsorted_array_tb;

  localparam int RAND_ITEMS   = 1450;
  localparam int PHASE1_AT    = 500;   // accepted words before the idle rates swap
  localparam int PHASE2_AT    = 1000;  // accepted words before idling stops
  localparam int HOLD_AT      = 1200;  // accepted words before the long response stall
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 60;    // above the worst extract latency

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  pq_pkg::in_word_t  req = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  pq_pkg::out_word_t rsp;

  priority_queue_unsorted_array dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the queue contents, kept in insertion order.
  logic signed [31:0] q_val [pq_pkg::QUEUE_DEPTH];
  logic signed [31:0] q_pri [pq_pkg::QUEUE_DEPTH];
  int                 q_cnt = 0;

  pq_pkg::in_word_t  req_pend [$];   // words waiting to be offered
  pq_pkg::out_word_t rsp_due  [$];   // responses owed by the block, oldest first
  int                n_acc = 0;
  int                errors = 0;
  logic              req_took = 1'b0;
  int                send_idle;
  int                recv_idle;
  int                hold_left = 0;
  logic              hold_done = 1'b0;

  // Applies one operation to the shadow queue and returns the response it owes.
  function automatic pq_pkg::out_word_t pq_apply(pq_pkg::in_word_t w);
    pq_pkg::out_word_t r;
    int                i;
    int                best;
    logic              hit;
    r.result_value = '0;
    r.status = pq_pkg::ST_OK;
    case (w.op)
      pq_pkg::OP_INSERT: begin
        if (q_cnt >= pq_pkg::QUEUE_DEPTH) begin
          r.status = pq_pkg::ST_FULL;
        end else begin
          q_val[q_cnt] = w.item_value;
          q_pri[q_cnt] = w.item_priority;
          q_cnt++;
        end
      end
      pq_pkg::OP_EXTRACT, pq_pkg::OP_PEEK: begin
        if (q_cnt == 0) begin
          r.status = pq_pkg::ST_EMPTY;
        end else begin
          // strict greater-than keeps the earliest entry on a tie
          best = 0;
          for (i = 1; i < q_cnt; i++) begin
            if (q_pri[i] > q_pri[best]) best = i;
          end
          r.result_value = q_val[best];
          if (w.op == pq_pkg::OP_EXTRACT) begin
            for (i = best; i + 1 < q_cnt; i++) begin
              q_val[i] = q_val[i + 1];
              q_pri[i] = q_pri[i + 1];
            end
            q_cnt--;
          end
        end
      end
      pq_pkg::OP_MODIFY: begin
        hit = 1'b0;
        for (i = 0; i < q_cnt; i++) begin
          if (!hit && q_val[i] == w.item_value) begin
            q_pri[i] = w.item_priority;
            hit = 1'b1;
          end
        end
        r.status = hit ? pq_pkg::ST_OK : pq_pkg::ST_NOTFOUND;
      end
      pq_pkg::OP_CLEAR: q_cnt = 0;
      default: ;
    endcase
    r.entry_count_out = pq_pkg::COUNT_OUT_W'(q_cnt);
    return r;
  endfunction

  task automatic queue_word(logic [2:0] op, logic signed [31:0] v, logic signed [31:0] p);
    pq_pkg::in_word_t w;
    w.op = op;
    w.item_value = v;
    w.item_priority = p;
    req_pend.push_back(w);
  endtask

  // Small pool most of the time so that modify finds its target.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 7);
  endfunction

  // Narrow range for plenty of ties, with extremes and full-width values mixed in.
  function automatic logic signed [31:0] pick_priority();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7fff_ffff;
    if (r < 6) return $urandom;
    return $signed($urandom_range(0, 6)) - 3;
  endfunction

  // Idle rates by phase, keyed on how many words have gone in.
  always_comb begin
    if (n_acc < PHASE1_AT) begin
      send_idle = 17;
      recv_idle = 77;
    end else if (n_acc < PHASE2_AT) begin
      send_idle = 77;
      recv_idle = 17;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  // Request driver: a word stays put until the edge that accepts it.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (req_pend.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        req       <= req_pend.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side: random ready, plus one long stall so the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_acc >= HOLD_AT) begin
      rsp_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Monitor: checks each response word first, then predicts for an accepted request.
  always @(posedge clk) begin
    pq_pkg::out_word_t want;
    if (rst) begin
      req_took <= 1'b0;
    end else begin
      req_took <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (rsp_due.size() == 0) begin
          $error("response word with none owed: value %0d status %0d count %0d",
                 rsp.result_value, rsp.status, rsp.entry_count_out);
          errors++;
        end else begin
          want = rsp_due.pop_front();
          if (rsp.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   rsp.result_value);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.entry_count_out !== want.entry_count_out) begin
            $error("entry_count_out: expected %0d, got %0d", want.entry_count_out,
                   rsp.entry_count_out);
            errors++;
          end
        end
      end
      if (req_valid && req_ready) begin
        rsp_due.push_back(pq_apply(req));
        n_acc++;
      end
    end
  end

  initial begin
    int k;
    int mode;
    int run_left;
    int roll;
    int ins_pct;
    int ext_pct;
    logic [2:0] op;

    // empty queue: peek, extract and modify all have nothing to work on
    queue_word(pq_pkg::OP_PEEK, 0, 0);
    queue_word(pq_pkg::OP_EXTRACT, 0, 0);
    queue_word(pq_pkg::OP_MODIFY, 5, 9);
    // fill to the brim, extremes first, with ties on the top priority
    queue_word(pq_pkg::OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    queue_word(pq_pkg::OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    queue_word(pq_pkg::OP_INSERT, 0, 0);
    queue_word(pq_pkg::OP_INSERT, -1, -1);
    for (k = 4; k < pq_pkg::QUEUE_DEPTH; k++) begin
      queue_word(pq_pkg::OP_INSERT, k + 100, (k % 3 == 0) ? 32'h7fff_ffff : k % 4);
    end
    queue_word(pq_pkg::OP_INSERT, 42, 1);                        // full, dropped
    queue_word(pq_pkg::OP_PEEK, 0, 0);
    queue_word(pq_pkg::OP_MODIFY, 32'h7fff_ffff, 32'h7fff_ffff); // ties, earlier entry keeps top
    queue_word(pq_pkg::OP_MODIFY, 12345, 3);                     // no match
    queue_word(pq_pkg::OP_EXTRACT, 0, 0);
    queue_word(pq_pkg::OP_EXTRACT, 0, 0);
    queue_word(3'd5, 1, 1);
    queue_word(3'd7, -1, -1);
    queue_word(pq_pkg::OP_CLEAR, 0, 0);

    // random runs: fill-heavy, drain-heavy or mixed, with random content
    run_left = 0;
    mode = 0;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (run_left == 0) begin
        mode = $urandom_range(0, 2);
        run_left = $urandom_range(4, 40);
      end
      run_left--;
      case (mode)
        0: begin ins_pct = 70; ext_pct = 10; end
        1: begin ins_pct = 15; ext_pct = 55; end
        default: begin ins_pct = 40; ext_pct = 30; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) op = pq_pkg::OP_INSERT;
      else if (roll < ins_pct + ext_pct) op = pq_pkg::OP_EXTRACT;
      else if (roll < 97) op = $urandom_range(0, 1) ? pq_pkg::OP_PEEK : pq_pkg::OP_MODIFY;
      else if (roll < 98) op = pq_pkg::OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      queue_word(op, pick_value(), pick_priority());
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_pend.size() != 0 || req_valid) @(posedge clk);
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("priority_queue_unsorted_array_tb: clean");
    end else begin
      $display("priority_queue_unsorted_array_tb: errors");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #1000000;
    $display("priority_queue_unsorted_array_tb: errors");
    $finish;
  end

endmodule
